[rtl/awba_pkg.sv]
// ----------------------------------------------------------------------------
// awba_pkg - shared types and constants of the window bound adjuster
// Command codes, configuration register indexes, bound limits, divider
// widths, and the sequencer state and control types.
// ----------------------------------------------------------------------------
package awba_pkg;

  // bound limits
  localparam logic signed [15:0] WIN_MAX = 16'sh7FFF;
  localparam logic signed [15:0] WIN_MIN = 16'sh8000;

  // command codes
  localparam logic [3:0] CMD_INC_UPPER   = 4'd0;
  localparam logic [3:0] CMD_DEC_UPPER   = 4'd1;
  localparam logic [3:0] CMD_INC_LOWER   = 4'd2;
  localparam logic [3:0] CMD_DEC_LOWER   = 4'd3;
  localparam logic [3:0] CMD_INC_STEP    = 4'd4;
  localparam logic [3:0] CMD_DEC_STEP    = 4'd5;
  localparam logic [3:0] CMD_SWAP        = 4'd6;
  localparam logic [3:0] CMD_RESET       = 4'd7;
  localparam logic [3:0] CMD_SLIDE_UPPER = 4'd8;
  localparam logic [3:0] CMD_SLIDE_LOWER = 4'd9;

  // last button code, zero means no button yet
  localparam logic [2:0] DIR_NONE = 3'd0;

  // configuration register indexes
  localparam logic [2:0] CFG_FAST_INTERVAL   = 3'd0;
  localparam logic [2:0] CFG_ACCEL_FACTOR    = 3'd1;
  localparam logic [2:0] CFG_MAX_STEP        = 3'd2;
  localparam logic [2:0] CFG_RANGE_MIN       = 3'd3;
  localparam logic [2:0] CFG_RANGE_MAX       = 3'd4;
  localparam logic [2:0] CFG_SLIDER_WIDTH    = 3'd5;
  localparam logic [2:0] CFG_KNOB_HALF_WIDTH = 3'd6;
  localparam logic [2:0] CFG_LABEL_WIDTH     = 3'd7;

  // slider divider: quotient bits and iteration counter width
  localparam int DIV_BITS = 28;
  localparam int CNT_W    = 5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_LOAD,
    S_DIV,
    S_FIN
  } awba_state_t;

  // sequencer controls
  typedef struct packed {
    logic in_ready;
    logic commit;
  } awba_ctrl_t;

endpackage

[rtl/accelerated_window_bound_adjuster_unit.sv]
// ----------------------------------------------------------------------------
// accelerated_window_bound_adjuster_unit - display window bound adjuster
// Keeps lower and upper window bounds and a step size, moved by button,
// step, swap, reset and slider requests, one result per request.
// ----------------------------------------------------------------------------
// One request is worked on at a time. A button, step, swap, reset or unused
// command, and a slider command whose span is not positive, goes through the
// prepare, multiply and finish states after it is accepted; a slider command
// with a positive span also goes through the load state and the restoring
// divider that scales the cursor and retires one of 28 quotient bits per
// cycle. A single multiplier serves both the increment cap (step times
// acceleration) and the slider product. The input is ready again from the
// clock edge that loads the result register, and a result waiting on
// out_ready does not block the next request until that request's result is due.
module accelerated_window_bound_adjuster_unit (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_command,
  input  logic [31:0]        in_event_time,
  input  logic [11:0]        in_cursor_x,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_lower_bound,
  output logic signed [15:0] out_upper_bound,
  output logic [10:0]        out_step_value,
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int DIV_BITS_L = awba_pkg::DIV_BITS;

  // configuration registers
  logic [31:0]        fast_interval_r;
  logic [6:0]         accel_factor_r;
  logic [10:0]        max_step_r;
  logic signed [15:0] range_min_r;
  logic signed [15:0] range_max_r;
  logic [11:0]        slider_width_r;
  logic [7:0]         knob_half_width_r;
  logic [11:0]        label_width_r;

  // block state
  logic signed [15:0] lower_value_r, lower_value_nxt;
  logic signed [15:0] upper_value_r, upper_value_nxt;
  logic [10:0]        step_size_r, step_size_nxt;
  logic [17:0]        increment_r, increment_nxt;
  logic [2:0]         last_dir_r, last_dir_nxt;
  logic [31:0]        last_time_r, last_time_nxt;

  // request registers
  logic [3:0]         cmd_r;
  logic [31:0]        time_r;
  logic [11:0]        cursor_r;

  // datapath registers
  logic signed [17:0] op_a_r;
  logic signed [12:0] op_b_r;
  logic signed [30:0] prod_r;
  logic               hit_r;
  logic               span_ok_r;
  logic [11:0]        span_r;
  logic               neg_r;
  logic [DIV_BITS_L-1:0] quo_r;
  logic [11:0]        rem_r;
  logic [awba_pkg::CNT_W-1:0] cnt_r;

  // result register
  logic               out_valid_r;
  logic signed [15:0] out_lower_r;
  logic signed [15:0] out_upper_r;
  logic [10:0]        out_step_r;

  awba_pkg::awba_state_t state_r, state_nxt;
  awba_pkg::awba_ctrl_t  ctrl;

  logic in_fire;
  logic is_button;
  logic is_slider;
  logic div_last;
  logic [2:0] dir;

  assign in_fire   = in_valid && ctrl.in_ready;
  assign is_button = (cmd_r == awba_pkg::CMD_INC_UPPER) || (cmd_r == awba_pkg::CMD_DEC_UPPER) ||
                     (cmd_r == awba_pkg::CMD_INC_LOWER) || (cmd_r == awba_pkg::CMD_DEC_LOWER);
  assign is_slider = (cmd_r == awba_pkg::CMD_SLIDE_UPPER) ||
                     (cmd_r == awba_pkg::CMD_SLIDE_LOWER);
  assign div_last  = (cnt_r == awba_pkg::CNT_W'(DIV_BITS_L - 1));
  assign dir       = {1'b0, cmd_r[1:0]} + 3'd1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      awba_pkg::S_IDLE: if (in_valid) state_nxt = awba_pkg::S_PREP;
      awba_pkg::S_PREP: state_nxt = awba_pkg::S_MUL;
      awba_pkg::S_MUL: begin
        if (is_slider && span_ok_r) state_nxt = awba_pkg::S_LOAD;
        else state_nxt = awba_pkg::S_FIN;
      end
      awba_pkg::S_LOAD: state_nxt = awba_pkg::S_DIV;
      awba_pkg::S_DIV: if (div_last) state_nxt = awba_pkg::S_FIN;
      awba_pkg::S_FIN: if (!out_valid_r || out_ready) state_nxt = awba_pkg::S_IDLE;
      default: state_nxt = awba_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl = '0;
    case (state_r)
      awba_pkg::S_IDLE: ctrl.in_ready = 1'b1;
      awba_pkg::S_FIN:  ctrl.commit   = !out_valid_r || out_ready;
      default: ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= awba_pkg::S_IDLE;
    else state_r <= state_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_interval_r   <= 32'd300;
      accel_factor_r    <= 7'd4;
      max_step_r        <= 11'd64;
      range_min_r       <= awba_pkg::WIN_MIN;
      range_max_r       <= awba_pkg::WIN_MAX;
      slider_width_r    <= 12'd256;
      knob_half_width_r <= 8'd8;
      label_width_r     <= 12'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        awba_pkg::CFG_FAST_INTERVAL:   fast_interval_r   <= cfg_data;
        awba_pkg::CFG_ACCEL_FACTOR:    accel_factor_r    <= cfg_data[6:0];
        awba_pkg::CFG_MAX_STEP:        max_step_r        <= cfg_data[10:0];
        awba_pkg::CFG_RANGE_MIN:       range_min_r       <= $signed(cfg_data[15:0]);
        awba_pkg::CFG_RANGE_MAX:       range_max_r       <= $signed(cfg_data[15:0]);
        awba_pkg::CFG_SLIDER_WIDTH:    slider_width_r    <= cfg_data[11:0];
        awba_pkg::CFG_KNOB_HALF_WIDTH: knob_half_width_r <= cfg_data[7:0];
        awba_pkg::CFG_LABEL_WIDTH:     label_width_r     <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // slider cursor clamp and operand selection
  logic signed [12:0] x_raw, x_lo, x_cl, cw_s, hi_s, d_s;
  logic signed [13:0] span_s;
  logic signed [16:0] diff_s;
  logic [31:0]        gap;

  always_comb begin
    cw_s   = $signed({5'b0, knob_half_width_r});
    x_raw  = $signed({1'b0, cursor_r}) - $signed({1'b0, label_width_r});
    hi_s   = $signed({1'b0, slider_width_r}) - cw_s;
    span_s = $signed({2'b0, slider_width_r}) - $signed({5'b0, knob_half_width_r, 1'b0});
    x_lo   = (x_raw < cw_s) ? cw_s : x_raw;
    x_cl   = (x_lo > hi_s) ? hi_s : x_lo;
    d_s    = x_cl - cw_s;
    diff_s = $signed({range_max_r[15], range_max_r}) - $signed({range_min_r[15], range_min_r});
    gap    = time_r - last_time_r;
  end

  // shared multiplier
  logic signed [30:0] prod_c;
  assign prod_c = 31'(op_a_r) * 31'(op_b_r);

  // restoring divider step
  logic [12:0] trial;
  logic        q_bit;
  assign trial = {rem_r, quo_r[DIV_BITS_L-1]};
  assign q_bit = (trial >= {1'b0, span_r});

  // datapath sequencing
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r    <= in_command;
      time_r   <= in_event_time;
      cursor_r <= in_cursor_x;
    end
    case (state_r)
      awba_pkg::S_PREP: begin
        hit_r     <= (gap <= fast_interval_r) && (last_dir_r == dir);
        span_ok_r <= (span_s > 14'sd0);
        span_r    <= span_s[11:0];
        if (is_slider) begin
          op_a_r <= {diff_s[16], diff_s};
          op_b_r <= $signed({1'b0, d_s[11:0]});
        end else begin
          op_a_r <= $signed({7'b0, step_size_r});
          op_b_r <= $signed({6'b0, accel_factor_r});
        end
      end
      awba_pkg::S_MUL: prod_r <= prod_c;
      awba_pkg::S_LOAD: begin
        neg_r <= prod_r[30];
        quo_r <= prod_r[30] ? DIV_BITS_L'(-prod_r) : DIV_BITS_L'(prod_r);
        rem_r <= '0;
        cnt_r <= '0;
      end
      awba_pkg::S_DIV: begin
        rem_r <= q_bit ? 12'(trial - {1'b0, span_r}) : trial[11:0];
        quo_r <= {quo_r[DIV_BITS_L-2:0], q_bit};
        cnt_r <= cnt_r + 1'b1;
      end
      default: ;
    endcase
  end

  // new block state at the end of a request
  logic [18:0]        inc_sum;
  logic [18:0]        inc_cap;
  logic [17:0]        inc_new;
  logic signed [19:0] btn_base, btn_res;
  logic signed [15:0] btn_sat;
  logic [10:0]        ms;
  logic [11:0]        step_up;
  logic signed [28:0] q_s;
  logic signed [29:0] slide_res;
  logic signed [15:0] slide_sat;

  always_comb begin
    inc_sum = {1'b0, increment_r} + {8'b0, step_size_r};
    inc_cap = {1'b0, prod_r[17:0]};
    if (hit_r) inc_new = (inc_sum < inc_cap) ? inc_sum[17:0] : inc_cap[17:0];
    else inc_new = {7'b0, step_size_r};

    btn_base = cmd_r[1] ? 20'(lower_value_r) : 20'(upper_value_r);
    if (cmd_r[0]) btn_res = btn_base - $signed({2'b0, inc_new});
    else btn_res = btn_base + $signed({2'b0, inc_new});
    if (btn_res > 20'sd32767) btn_sat = awba_pkg::WIN_MAX;
    else if (btn_res < -20'sd32768) btn_sat = awba_pkg::WIN_MIN;
    else btn_sat = btn_res[15:0];

    ms      = (max_step_r == 11'd0) ? 11'd1 : max_step_r;
    step_up = {1'b0, step_size_r} + 12'd1;

    q_s       = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
    slide_res = 30'(range_min_r) + 30'(q_s);
    if (slide_res > 30'sd32767) slide_sat = awba_pkg::WIN_MAX;
    else if (slide_res < -30'sd32768) slide_sat = awba_pkg::WIN_MIN;
    else slide_sat = slide_res[15:0];

    lower_value_nxt = lower_value_r;
    upper_value_nxt = upper_value_r;
    step_size_nxt   = step_size_r;
    increment_nxt   = increment_r;
    last_dir_nxt    = last_dir_r;
    last_time_nxt   = last_time_r;

    if (is_button) begin
      increment_nxt = inc_new;
      last_dir_nxt  = dir;
      last_time_nxt = time_r;
      if (cmd_r[1]) lower_value_nxt = btn_sat;
      else upper_value_nxt = btn_sat;
    end

    case (cmd_r)
      awba_pkg::CMD_INC_STEP: step_size_nxt = (step_up < {1'b0, ms}) ? step_up[10:0] : ms;
      awba_pkg::CMD_DEC_STEP: begin
        step_size_nxt = (step_size_r <= 11'd1) ? 11'd1 : step_size_r - 11'd1;
      end
      awba_pkg::CMD_SWAP: begin
        lower_value_nxt = upper_value_r;
        upper_value_nxt = lower_value_r;
      end
      awba_pkg::CMD_RESET: begin
        lower_value_nxt = range_min_r;
        upper_value_nxt = range_max_r;
      end
      awba_pkg::CMD_SLIDE_UPPER: if (span_ok_r) upper_value_nxt = slide_sat;
      awba_pkg::CMD_SLIDE_LOWER: if (span_ok_r) lower_value_nxt = slide_sat;
      default: ;
    endcase
  end

  // block state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_value_r <= '0;
      upper_value_r <= '0;
      step_size_r   <= 11'd1;
      increment_r   <= '0;
      last_dir_r    <= awba_pkg::DIR_NONE;
      last_time_r   <= '0;
    end else if (ctrl.commit) begin
      lower_value_r <= lower_value_nxt;
      upper_value_r <= upper_value_nxt;
      step_size_r   <= step_size_nxt;
      increment_r   <= increment_nxt;
      last_dir_r    <= last_dir_nxt;
      last_time_r   <= last_time_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (ctrl.commit) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      out_lower_r <= lower_value_nxt;
      out_upper_r <= upper_value_nxt;
      out_step_r  <= step_size_nxt;
    end
  end

  assign in_ready        = ctrl.in_ready;
  assign out_valid       = out_valid_r;
  assign out_lower_bound = out_lower_r;
  assign out_upper_bound = out_upper_r;
  assign out_step_value  = out_step_r;

`ifndef SYNTHESIS
  // step size never drops to zero
  a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    step_size_r != 11'd0)
    else $error("step size reached zero");

  // divider remainder stays below the span
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == awba_pkg::S_DIV) |-> (rem_r < span_r))
    else $error("divider remainder out of range");

  // last divider step hands over to the finish state
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == awba_pkg::S_DIV && div_last) |=> (state_r == awba_pkg::S_FIN))
    else $error("divider did not finish");

  // bounds change only when a request commits
  a_bounds_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ctrl.commit |=> ($stable(lower_value_r) && $stable(upper_value_r)))
    else $error("bounds changed without a commit");

  // an accepted request blocks the input until its result is due
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("input ready while busy");
`endif

endmodule

[sim/accelerated_window_bound_adjuster_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accelerated_window_bound_adjuster_unit_tb - window bound adjuster testbench
// Sends button, step, swap, reset, slider and unused-code requests in random
// bursts and stalls the result channel on its own pattern. Every result is
// checked against a behavioral model of the bounds, the step size and the
// click acceleration. The registers are reprogrammed between phases.
// ----------------------------------------------------------------------------
module accelerated_window_bound_adjuster_unit_tb;

  localparam int IDLE_LIMIT     = 5000;
  localparam int PHASE_COUNT    = 9;
  localparam int PHASE_REQUESTS = 110;
  localparam int DRAIN_CYCLES   = 40;
  localparam int REPORT_LIMIT   = 10;
  localparam logic [3:0] CMD_TOP = 4'hF;

  typedef struct packed {
    logic [3:0]  command;
    logic [31:0] event_time;
    logic [11:0] cursor_x;
  } request_t;

  typedef struct packed {
    logic signed [15:0] lower_bound;
    logic signed [15:0] upper_bound;
    logic [10:0]        step_value;
  } window_t;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic [3:0]         in_command    = awba_pkg::CMD_INC_UPPER;
  logic [31:0]        in_event_time = '0;
  logic [11:0]        in_cursor_x   = '0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic signed [15:0] out_lower_bound;
  logic signed [15:0] out_upper_bound;
  logic [10:0]        out_step_value;
  logic               cfg_valid     = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index     = awba_pkg::CFG_FAST_INTERVAL;
  logic [31:0]        cfg_data      = '0;

  request_t pending_requests[$];
  window_t  expected_windows[$];
  int       bad_results = 0;
  int       idle_cycles = 0;
  int       burst_left  = 1;
  int       gap_left    = 0;
  int       stall_mode  = 0;
  int       stall_left  = 0;

  // model state, reset values
  logic signed [15:0] lower_q      = '0;
  logic signed [15:0] upper_q      = '0;
  logic [10:0]        step_q       = 11'd1;
  int unsigned        incr_q       = 0;
  logic [2:0]         last_btn_q   = awba_pkg::DIR_NONE;
  logic [31:0]        last_click_q = '0;

  // model registers, reset values
  logic [31:0]        fast_q       = 32'd300;
  logic [6:0]         accel_q      = 7'd4;
  logic [10:0]        max_step_q   = 11'd64;
  logic signed [15:0] range_min_q  = awba_pkg::WIN_MIN;
  logic signed [15:0] range_max_q  = awba_pkg::WIN_MAX;
  logic [11:0]        slider_w_q   = 12'd256;
  logic [7:0]         knob_half_q  = 8'd8;
  logic [11:0]        label_w_q    = 12'd0;

  accelerated_window_bound_adjuster_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_event_time  (in_event_time),
    .in_cursor_x    (in_cursor_x),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_lower_bound(out_lower_bound),
    .out_upper_bound(out_upper_bound),
    .out_step_value (out_step_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // saturate to the 16-bit bound range
  function automatic logic signed [15:0] clamp_bound(input longint v);
    if (v > longint'(awba_pkg::WIN_MAX)) return awba_pkg::WIN_MAX;
    if (v < longint'(awba_pkg::WIN_MIN)) return awba_pkg::WIN_MIN;
    return v[15:0];
  endfunction

  // button click: restart or accelerate the increment, then move one bound
  task automatic press_button(input logic [3:0] cmd, input logic [31:0] t);
    logic [2:0]  btn;
    logic [31:0] gap;
    int unsigned sum;
    int unsigned cap;
    btn = cmd[2:0] + 3'd1;
    gap = t - last_click_q;
    if (gap <= fast_q && last_btn_q == btn) begin
      sum = incr_q + step_q;
      cap = step_q * accel_q;
      incr_q = (sum < cap) ? sum : cap;
    end else begin
      incr_q = step_q;
      last_btn_q = btn;
    end
    last_click_q = t;
    case (cmd)
      awba_pkg::CMD_INC_UPPER:
        upper_q = clamp_bound(longint'(upper_q) + longint'(incr_q));
      awba_pkg::CMD_DEC_UPPER:
        upper_q = clamp_bound(longint'(upper_q) - longint'(incr_q));
      awba_pkg::CMD_INC_LOWER:
        lower_q = clamp_bound(longint'(lower_q) + longint'(incr_q));
      awba_pkg::CMD_DEC_LOWER:
        lower_q = clamp_bound(longint'(lower_q) - longint'(incr_q));
      default: ;
    endcase
  endtask

  // slider: clamp the cursor to the track and scale it into the range
  task automatic slide_bound(input logic is_upper, input logic [11:0] cx);
    int                 cw;
    int                 span;
    int                 x;
    longint             prod;
    logic signed [15:0] v;
    cw = int'(knob_half_q);
    span = int'(slider_w_q) - 2 * cw;
    x = int'(cx) - int'(label_w_q);
    if (span <= 0) return;
    if (x < cw) x = cw;
    if (x > int'(slider_w_q) - cw) x = int'(slider_w_q) - cw;
    prod = longint'(int'(range_max_q) - int'(range_min_q)) * longint'(x - cw);
    v = clamp_bound(longint'(range_min_q) + prod / longint'(span));
    if (is_upper) upper_q = v;
    else lower_q = v;
  endtask

  // apply one accepted request and queue the window it must report
  task automatic advance_window(input request_t req);
    logic [10:0]        ms;
    logic signed [15:0] held;
    window_t            w;
    ms = (max_step_q == '0) ? 11'd1 : max_step_q;
    case (req.command)
      awba_pkg::CMD_INC_UPPER, awba_pkg::CMD_DEC_UPPER,
      awba_pkg::CMD_INC_LOWER, awba_pkg::CMD_DEC_LOWER:
        press_button(req.command, req.event_time);
      awba_pkg::CMD_INC_STEP: begin
        if (int'(step_q) + 1 < int'(ms)) step_q = step_q + 11'd1;
        else step_q = ms;
      end
      awba_pkg::CMD_DEC_STEP: begin
        if (step_q > 11'd1) step_q = step_q - 11'd1;
        else step_q = 11'd1;
      end
      awba_pkg::CMD_SWAP: begin
        held = lower_q;
        lower_q = upper_q;
        upper_q = held;
      end
      awba_pkg::CMD_RESET: begin
        lower_q = range_min_q;
        upper_q = range_max_q;
      end
      awba_pkg::CMD_SLIDE_UPPER: slide_bound(1'b1, req.cursor_x);
      awba_pkg::CMD_SLIDE_LOWER: slide_bound(1'b0, req.cursor_x);
      default: ;
    endcase
    w.lower_bound = lower_q;
    w.upper_bound = upper_q;
    w.step_value  = step_q;
    expected_windows.push_back(w);
  endtask

  task automatic queue_request(input logic [3:0] cmd, input logic [31:0] t,
                               input logic [11:0] cx);
    request_t req;
    req.command    = cmd;
    req.event_time = t;
    req.cursor_x   = cx;
    pending_requests.push_back(req);
  endtask

  // click gap: mostly inside the fast interval, sometimes on or past its edge
  function automatic logic [31:0] click_gap();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return $urandom_range(0, (fast_q < 32'd1000) ? fast_q : 32'd1000);
    if (pick < 6) return $urandom_range(0, fast_q);
    if (pick == 6) return fast_q;
    if (pick == 7) return fast_q + 32'd1;
    if (pick == 8) return '0;
    return $urandom;
  endfunction

  // random requests: button runs dominate, then step runs, swap, reset, slider and noise
  task automatic queue_random_phase(input int count);
    int          made;
    int          roll;
    int          cx;
    logic [3:0]  cmd;
    logic [31:0] now_ms;
    made = 0;
    now_ms = $urandom;
    while (made < count) begin
      roll = $urandom_range(0, 19);
      if (roll <= 10) begin
        cmd = 4'($urandom_range(awba_pkg::CMD_INC_UPPER, awba_pkg::CMD_DEC_LOWER));
        repeat ($urandom_range(1, 10)) begin
          now_ms = now_ms + click_gap();
          queue_request(cmd, now_ms, 12'($urandom_range(0, 4095)));
          made++;
        end
      end else if (roll <= 12) begin
        cmd = ($urandom_range(0, 9) < 7) ? awba_pkg::CMD_INC_STEP : awba_pkg::CMD_DEC_STEP;
        repeat ($urandom_range(1, (cmd == awba_pkg::CMD_INC_STEP) ? 30 : 10)) begin
          queue_request(cmd, $urandom, 12'($urandom_range(0, 4095)));
          made++;
        end
      end else if (roll == 13) begin
        queue_request(awba_pkg::CMD_SWAP, $urandom, 12'($urandom_range(0, 4095)));
        made++;
      end else if (roll == 14) begin
        queue_request(awba_pkg::CMD_RESET, $urandom, 12'($urandom_range(0, 4095)));
        made++;
      end else if (roll <= 17) begin
        cmd = $urandom_range(0, 1) ? awba_pkg::CMD_SLIDE_UPPER : awba_pkg::CMD_SLIDE_LOWER;
        if ($urandom_range(0, 1)) begin
          cx = int'(label_w_q) + $urandom_range(0, slider_w_q);
          if (cx > 4095) cx = 4095;
        end else begin
          cx = $urandom_range(0, 4095);
        end
        queue_request(cmd, $urandom, 12'(cx));
        made++;
      end else if (roll == 18) begin
        queue_request(4'($urandom_range(awba_pkg::CMD_SLIDE_LOWER + 1, CMD_TOP)), $urandom,
                      12'($urandom_range(0, 4095)));
        made++;
      end else begin
        queue_request(4'($urandom), $urandom, 12'($urandom_range(0, 4095)));
        made++;
      end
    end
  endtask

  // one register write, model copy updated on the accepting edge
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      awba_pkg::CFG_FAST_INTERVAL:   fast_q      = val;
      awba_pkg::CFG_ACCEL_FACTOR:    accel_q     = val[6:0];
      awba_pkg::CFG_MAX_STEP:        max_step_q  = val[10:0];
      awba_pkg::CFG_RANGE_MIN:       range_min_q = val[15:0];
      awba_pkg::CFG_RANGE_MAX:       range_max_q = val[15:0];
      awba_pkg::CFG_SLIDER_WIDTH:    slider_w_q  = val[11:0];
      awba_pkg::CFG_KNOB_HALF_WIDTH: knob_half_q = val[7:0];
      awba_pkg::CFG_LABEL_WIDTH:     label_w_q   = val[11:0];
      default: ;
    endcase
  endtask

  // register settings per phase, extremes first, random in between
  task automatic program_phase(input int phase);
    logic [31:0] vals [8];
    case (phase)
      1: begin
        vals[awba_pkg::CFG_FAST_INTERVAL]   = 32'd0;
        vals[awba_pkg::CFG_ACCEL_FACTOR]    = 32'd1;
        vals[awba_pkg::CFG_MAX_STEP]        = 32'd1;
        vals[awba_pkg::CFG_RANGE_MIN]       = 32'hFFFF_8000;
        vals[awba_pkg::CFG_RANGE_MAX]       = 32'h0000_7FFF;
        vals[awba_pkg::CFG_SLIDER_WIDTH]    = 32'd4095;
        vals[awba_pkg::CFG_KNOB_HALF_WIDTH] = 32'd0;
        vals[awba_pkg::CFG_LABEL_WIDTH]     = 32'd0;
      end
      2: begin
        // widest interval, max step 1024, reversed range
        vals[awba_pkg::CFG_FAST_INTERVAL]   = 32'hFFFF_FFFF;
        vals[awba_pkg::CFG_ACCEL_FACTOR]    = 32'd64;
        vals[awba_pkg::CFG_MAX_STEP]        = 32'd1024;
        vals[awba_pkg::CFG_RANGE_MIN]       = 32'h0000_7FFF;
        vals[awba_pkg::CFG_RANGE_MAX]       = 32'hFFFF_8000;
        vals[awba_pkg::CFG_SLIDER_WIDTH]    = 32'd4095;
        vals[awba_pkg::CFG_KNOB_HALF_WIDTH] = 32'd255;
        vals[awba_pkg::CFG_LABEL_WIDTH]     = 32'd4095;
      end
      3: begin
        // zero acceleration, zero max step, empty slider span
        vals[awba_pkg::CFG_FAST_INTERVAL]   = 32'd1000;
        vals[awba_pkg::CFG_ACCEL_FACTOR]    = 32'd0;
        vals[awba_pkg::CFG_MAX_STEP]        = 32'd0;
        vals[awba_pkg::CFG_RANGE_MIN]       = 32'd100;
        vals[awba_pkg::CFG_RANGE_MAX]       = 32'hFFFF_FF9C;
        vals[awba_pkg::CFG_SLIDER_WIDTH]    = 32'd10;
        vals[awba_pkg::CFG_KNOB_HALF_WIDTH] = 32'd5;
        vals[awba_pkg::CFG_LABEL_WIDTH]     = 32'd7;
      end
      5: begin
        vals[awba_pkg::CFG_FAST_INTERVAL]   = 32'd50;
        vals[awba_pkg::CFG_ACCEL_FACTOR]    = 32'd127;
        vals[awba_pkg::CFG_MAX_STEP]        = 32'd2047;
        vals[awba_pkg::CFG_RANGE_MIN]       = 32'hFFFF_FFFF;
        vals[awba_pkg::CFG_RANGE_MAX]       = 32'd0;
        vals[awba_pkg::CFG_SLIDER_WIDTH]    = 32'd600;
        vals[awba_pkg::CFG_KNOB_HALF_WIDTH] = 32'd40;
        vals[awba_pkg::CFG_LABEL_WIDTH]     = 32'd100;
      end
      6: begin
        // max step below the grown step size, negative slider span
        vals[awba_pkg::CFG_FAST_INTERVAL]   = 32'd500;
        vals[awba_pkg::CFG_ACCEL_FACTOR]    = 32'd8;
        vals[awba_pkg::CFG_MAX_STEP]        = 32'd16;
        vals[awba_pkg::CFG_RANGE_MIN]       = 32'hFFFF_8000;
        vals[awba_pkg::CFG_RANGE_MAX]       = 32'h0000_7FFF;
        vals[awba_pkg::CFG_SLIDER_WIDTH]    = 32'd300;
        vals[awba_pkg::CFG_KNOB_HALF_WIDTH] = 32'd200;
        vals[awba_pkg::CFG_LABEL_WIDTH]     = 32'd0;
      end
      9: begin
        vals[awba_pkg::CFG_FAST_INTERVAL]   = 32'd300;
        vals[awba_pkg::CFG_ACCEL_FACTOR]    = 32'd4;
        vals[awba_pkg::CFG_MAX_STEP]        = 32'd64;
        vals[awba_pkg::CFG_RANGE_MIN]       = 32'hFFFF_8000;
        vals[awba_pkg::CFG_RANGE_MAX]       = 32'h0000_7FFF;
        vals[awba_pkg::CFG_SLIDER_WIDTH]    = 32'd1;
        vals[awba_pkg::CFG_KNOB_HALF_WIDTH] = 32'd0;
        vals[awba_pkg::CFG_LABEL_WIDTH]     = 32'd2048;
      end
      default: begin
        vals[awba_pkg::CFG_FAST_INTERVAL] =
          $urandom_range(0, 1) ? $urandom_range(0, 2000) : $urandom;
        vals[awba_pkg::CFG_ACCEL_FACTOR]    = $urandom;
        vals[awba_pkg::CFG_MAX_STEP] =
          $urandom_range(0, 1) ? $urandom_range(0, 64) : $urandom;
        vals[awba_pkg::CFG_RANGE_MIN]       = $urandom;
        vals[awba_pkg::CFG_RANGE_MAX]       = $urandom;
        vals[awba_pkg::CFG_SLIDER_WIDTH]    = $urandom;
        vals[awba_pkg::CFG_KNOB_HALF_WIDTH] = $urandom;
        vals[awba_pkg::CFG_LABEL_WIDTH] =
          $urandom_range(0, 1) ? $urandom_range(0, 200) : $urandom;
      end
    endcase
    @(posedge clk);
    for (int r = awba_pkg::CFG_FAST_INTERVAL; r <= awba_pkg::CFG_LABEL_WIDTH; r++)
      write_reg(3'(r), vals[r]);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // wait until every request is sent and every result is back
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_windows.size() != 0);
  endtask

  // request driver: bursts from the pending queue with random gaps
  always @(posedge clk) begin
    request_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = $urandom_range(1, 24);
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        req.command    = in_command;
        req.event_time = in_event_time;
        req.cursor_x   = in_cursor_x;
        advance_window(req);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          req = pending_requests.pop_front();
          in_valid      <= 1'b1;
          in_command    <= req.command;
          in_event_time <= req.event_time;
          in_cursor_x   <= req.cursor_x;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall pattern
  always @(posedge clk) begin
    window_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_windows.size() == 0) begin
          if (bad_results < REPORT_LIMIT)
            $display("unexpected result: lower %0d upper %0d step %0d",
                     out_lower_bound, out_upper_bound, out_step_value);
          bad_results++;
        end else begin
          want = expected_windows.pop_front();
          if (out_lower_bound !== want.lower_bound ||
              out_upper_bound !== want.upper_bound ||
              out_step_value !== want.step_value) begin
            if (bad_results < REPORT_LIMIT)
              $display("mismatch: expected lower %0d upper %0d step %0d, %s %0d %0d %0d",
                       $signed(want.lower_bound), $signed(want.upper_bound),
                       want.step_value, "got lower/upper/step",
                       out_lower_bound, out_upper_bound, out_step_value);
            bad_results++;
          end
        end
      end
      // stall mode is redrawn whenever its run counter reaches zero
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(16, 160);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0, 1: out_ready <= 1'b1;
        2: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // reset, directed requests, then random phases under changing settings
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // acceleration up to the cap, interval edge, restart past it
    queue_request(awba_pkg::CMD_INC_UPPER, 32'd0, 12'd0);
    queue_request(awba_pkg::CMD_INC_UPPER, 32'd100, 12'hFFF);
    queue_request(awba_pkg::CMD_INC_UPPER, 32'd400, 12'd0);
    queue_request(awba_pkg::CMD_INC_UPPER, 32'd500, 12'd0);
    queue_request(awba_pkg::CMD_INC_UPPER, 32'd600, 12'd0);
    queue_request(awba_pkg::CMD_INC_UPPER, 32'd901, 12'd0);
    queue_request(awba_pkg::CMD_DEC_UPPER, 32'd950, 12'd0);
    queue_request(awba_pkg::CMD_INC_STEP, 32'd0, 12'd0);
    queue_request(awba_pkg::CMD_INC_STEP, 32'd0, 12'd0);
    // click timestamps wrapping around
    queue_request(awba_pkg::CMD_DEC_LOWER, 32'hFFFF_FF00, 12'd0);
    queue_request(awba_pkg::CMD_DEC_LOWER, 32'h0000_0010, 12'd0);
    queue_request(awba_pkg::CMD_INC_LOWER, 32'hFFFF_FFFF, 12'd0);
    // step size floor
    queue_request(awba_pkg::CMD_DEC_STEP, 32'd0, 12'd0);
    queue_request(awba_pkg::CMD_DEC_STEP, 32'd0, 12'd0);
    queue_request(awba_pkg::CMD_DEC_STEP, 32'd0, 12'd0);
    // full range, saturation at both ends, swap
    queue_request(awba_pkg::CMD_RESET, 32'hFFFF_FFFF, 12'hFFF);
    queue_request(awba_pkg::CMD_INC_UPPER, 32'd5000, 12'd0);
    queue_request(awba_pkg::CMD_DEC_LOWER, 32'd6000, 12'd0);
    queue_request(awba_pkg::CMD_SWAP, 32'd0, 12'd0);
    // slider clamps and a mid-track position
    queue_request(awba_pkg::CMD_SLIDE_UPPER, 32'd0, 12'd0);
    queue_request(awba_pkg::CMD_SLIDE_LOWER, 32'd0, 12'hFFF);
    queue_request(awba_pkg::CMD_SLIDE_UPPER, 32'd0, 12'd128);
    // unused command codes report the state unchanged
    queue_request(awba_pkg::CMD_SLIDE_LOWER + 4'd1, 32'd0, 12'd0);
    queue_request(CMD_TOP, 32'hFFFF_FFFF, 12'hFFF);
    wait_drained();

    for (int p = 1; p <= PHASE_COUNT; p++) begin
      program_phase(p);
      queue_random_phase(PHASE_REQUESTS);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_results == 0 && expected_windows.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/awba_pkg.sv
rtl/accelerated_window_bound_adjuster_unit.sv
sim/accelerated_window_bound_adjuster_unit_tb.sv
